// ----- sv/http_chunked_body_decoder_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the chunked body decoder checker.
// All properties sample on the rising edge of clk and are off during reset.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_MACROS_SVH

// Overlapping implication: the consequent holds in the same cycle.
`define HCBD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Non-overlapping implication: the consequent holds in the next cycle.
`define HCBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/hcbd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, character codes and helpers shared by the chunked body decoder files.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam int SIZE_BITS_DEFAULT = 32;
    localparam int COUNT_BITS        = 32;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam logic [1:0] STATUS_RUNNING    = 2'd0;
    localparam logic [1:0] STATUS_DONE       = 2'd1;
    localparam logic [1:0] STATUS_ERROR      = 2'd2;
    localparam logic [1:0] STATUS_INCOMPLETE = 2'd3;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_BAD,
        PH_DATA,
        PH_DCR,
        PH_DLF,
        PH_TRAILER,
        PH_DONE,
        PH_FAIL
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.valid = 1'b1;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d.value = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d.value = 4'(c - 8'h37);
        end
        else
        begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// ----- sv/http_chunked_body_decoder_unit.sv -----
`default_nettype none
// The result for a byte is registered and presented in the cycle after the beat is accepted.
// Throughput: one byte per cycle while the output is not stalled; the single result register sets the rate.
// The input stalls only while a held result is itself stalled at the output.
// Reset (rst_n low, asynchronous) returns the decoder to the start of a size line,
// clears all counters and line flags, and empties the result register.
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit
// Decodes an HTTP/1.1 chunked message body one byte per beat, passing chunk
// data out as body bytes and reporting done, error or incomplete status.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_unit
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  input_last,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       body_valid,
    output logic [7:0]                 body_byte,
    output logic [1:0]                 status,
    output logic [COUNT_BITS-1:0]      consumed_count
);

    phase_t                 phase_reg, phase_next;
    logic [SIZE_BITS-1:0]   size_accum_reg, size_accum_next;
    logic [SIZE_BITS-1:0]   data_remaining_reg, data_remaining_next;
    logic                   digit_seen_reg, digit_seen_next;
    logic                   digits_closed_reg, digits_closed_next;
    logic                   in_extension_reg, in_extension_next;
    logic                   cr_pending_reg, cr_pending_next;
    logic                   trailer_nonempty_reg, trailer_nonempty_next;
    logic                   trailer_colon_reg, trailer_colon_next;
    logic [COUNT_BITS-1:0]  byte_counter_reg, byte_counter_next;

    logic                   out_valid_reg;
    logic                   body_valid_reg, body_valid_next;
    logic [7:0]             body_byte_reg, body_byte_next;
    logic [1:0]             status_reg, status_next;
    logic [COUNT_BITS-1:0]  consumed_reg, consumed_next;

    logic                   accept;
    logic                   is_blank;
    logic [SIZE_BITS-1:0]   remaining_dec;
    hex_digit_t             digit;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign is_blank = (data_byte == CHAR_SPACE) || (data_byte == CHAR_TAB)
                   || (data_byte == CHAR_LF);
    assign digit         = hex_decode(data_byte);
    assign remaining_dec = data_remaining_reg - SIZE_BITS'(1);

    always_comb
    begin
        phase_next            = phase_reg;
        size_accum_next       = size_accum_reg;
        data_remaining_next   = data_remaining_reg;
        digit_seen_next       = digit_seen_reg;
        digits_closed_next    = digits_closed_reg;
        in_extension_next     = in_extension_reg;
        cr_pending_next       = cr_pending_reg;
        trailer_nonempty_next = trailer_nonempty_reg;
        trailer_colon_next    = trailer_colon_reg;
        byte_counter_next     = byte_counter_reg;
        body_valid_next       = 1'b0;
        body_byte_next        = 8'd0;

        if (phase_reg != PH_DONE && phase_reg != PH_FAIL)
        begin
            byte_counter_next = byte_counter_reg + COUNT_BITS'(1);
        end

        unique case (phase_reg)
            PH_SIZE, PH_BAD:
            begin
                if (cr_pending_reg && data_byte == CHAR_LF)
                begin
                    if (phase_reg == PH_BAD || !digit_seen_reg)
                    begin
                        phase_next = PH_FAIL;
                    end
                    else if (size_accum_reg == '0)
                    begin
                        phase_next = PH_TRAILER;
                    end
                    else
                    begin
                        data_remaining_next = size_accum_reg;
                        phase_next          = PH_DATA;
                    end
                    size_accum_next       = '0;
                    digit_seen_next       = 1'b0;
                    digits_closed_next    = 1'b0;
                    in_extension_next     = 1'b0;
                    cr_pending_next       = 1'b0;
                    trailer_nonempty_next = 1'b0;
                    trailer_colon_next    = 1'b0;
                end
                else
                begin
                    // A CR that was not followed by LF counts as a blank.
                    if (cr_pending_reg && phase_reg == PH_SIZE && !in_extension_reg
                        && digit_seen_reg)
                    begin
                        digits_closed_next = 1'b1;
                    end
                    cr_pending_next = (data_byte == CHAR_CR);
                    if (data_byte != CHAR_CR && phase_reg == PH_SIZE && !in_extension_reg)
                    begin
                        if (data_byte == CHAR_SEMI)
                        begin
                            in_extension_next = 1'b1;
                        end
                        else if (is_blank)
                        begin
                            if (digit_seen_reg)
                            begin
                                digits_closed_next = 1'b1;
                            end
                        end
                        else if (!digit.valid || digits_closed_next)
                        begin
                            phase_next = PH_BAD;
                        end
                        else if (size_accum_reg[SIZE_BITS-1 -: 4] != 4'd0)
                        begin
                            phase_next = PH_BAD;
                        end
                        else
                        begin
                            size_accum_next = {size_accum_reg[SIZE_BITS-5:0], digit.value};
                            digit_seen_next = 1'b1;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                body_valid_next     = 1'b1;
                body_byte_next      = data_byte;
                data_remaining_next = remaining_dec;
                if (remaining_dec == '0)
                begin
                    phase_next = PH_DCR;
                end
            end
            PH_DCR:
            begin
                phase_next = (data_byte == CHAR_CR) ? PH_DLF : PH_FAIL;
            end
            PH_DLF:
            begin
                phase_next = (data_byte == CHAR_LF) ? PH_SIZE : PH_FAIL;
            end
            PH_TRAILER:
            begin
                if (cr_pending_reg && data_byte == CHAR_LF)
                begin
                    if (!trailer_nonempty_reg)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (!trailer_colon_reg)
                    begin
                        phase_next = PH_FAIL;
                    end
                    size_accum_next       = '0;
                    digit_seen_next       = 1'b0;
                    digits_closed_next    = 1'b0;
                    in_extension_next     = 1'b0;
                    cr_pending_next       = 1'b0;
                    trailer_nonempty_next = 1'b0;
                    trailer_colon_next    = 1'b0;
                end
                else
                begin
                    if (cr_pending_reg || data_byte != CHAR_CR)
                    begin
                        trailer_nonempty_next = 1'b1;
                    end
                    cr_pending_next = (data_byte == CHAR_CR);
                    if (data_byte == CHAR_COLON)
                    begin
                        trailer_colon_next = 1'b1;
                    end
                end
            end
            PH_DONE, PH_FAIL:
            begin
            end
            default:
            begin
            end
        endcase

        consumed_next = '0;
        if (phase_next == PH_DONE)
        begin
            status_next   = STATUS_DONE;
            consumed_next = byte_counter_next;
        end
        else if (phase_next == PH_FAIL)
        begin
            status_next = STATUS_ERROR;
        end
        else if (input_last)
        begin
            status_next = STATUS_INCOMPLETE;
        end
        else
        begin
            status_next = STATUS_RUNNING;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_SIZE;
            size_accum_reg       <= '0;
            data_remaining_reg   <= '0;
            digit_seen_reg       <= 1'b0;
            digits_closed_reg    <= 1'b0;
            in_extension_reg     <= 1'b0;
            cr_pending_reg       <= 1'b0;
            trailer_nonempty_reg <= 1'b0;
            trailer_colon_reg    <= 1'b0;
            byte_counter_reg     <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg            <= phase_next;
                size_accum_reg       <= size_accum_next;
                data_remaining_reg   <= data_remaining_next;
                digit_seen_reg       <= digit_seen_next;
                digits_closed_reg    <= digits_closed_next;
                in_extension_reg     <= in_extension_next;
                cr_pending_reg       <= cr_pending_next;
                trailer_nonempty_reg <= trailer_nonempty_next;
                trailer_colon_reg    <= trailer_colon_next;
                byte_counter_reg     <= byte_counter_next;
                out_valid_reg        <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            body_valid_reg <= body_valid_next;
            body_byte_reg  <= body_byte_next;
            status_reg     <= status_next;
            consumed_reg   <= consumed_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign body_valid     = body_valid_reg;
    assign body_byte      = body_byte_reg;
    assign status         = status_reg;
    assign consumed_count = consumed_reg;

endmodule
`default_nettype wire

// ----- sv/hcbd_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_checker
// Port-level checks for the chunked body decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_unit_macros.svh"

module hcbd_checker
    import hcbd_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic                  body_valid,
    input wire logic [7:0]            body_byte,
    input wire logic [1:0]            status,
    input wire logic [COUNT_BITS-1:0] consumed_count
);

    logic done_seen_reg;

    // Set once a done status beat has been delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_seen_reg <= 1'b0;
        end
        else if (out_valid && !out_stall && status == STATUS_DONE)
        begin
            done_seen_reg <= 1'b1;
        end
    end

    `HCBD_ASSERT_NEXT(a_accept_gives_result, in_valid && !in_stall,
        out_valid, "accepted beat produced no result beat")
    `HCBD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(status) && $stable(body_byte) && $stable(consumed_count),
        "stalled result beat changed")
    `HCBD_ASSERT_SAME(a_done_sticky, done_seen_reg && out_valid,
        status == STATUS_DONE, "status left done")
    `HCBD_ASSERT_SAME(a_count_only_done, out_valid && status != STATUS_DONE,
        consumed_count == '0, "consumed count shown without done")
    `HCBD_ASSERT_SAME(a_no_body_when_final, out_valid && (body_valid == 1'b0),
        body_byte == 8'd0, "body byte nonzero without body valid")

endmodule

bind http_chunked_body_decoder_unit hcbd_checker u_hcbd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .body_valid     (body_valid),
    .body_byte      (body_byte),
    .status         (status),
    .consumed_count (consumed_count)
);
`default_nettype wire
